// ----- src/xcr_pkg.sv -----
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared types and protocol constants for the XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
package xcr_pkg;

  // block geometry
  localparam int BLOCK_BYTES = 128;
  localparam int CNT_W       = $clog2(BLOCK_BYTES);

  // item actions
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_REJECT = 2'd3;

  // line bytes
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_REQ = 8'h43;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CANCEL   = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd2;
  localparam logic [1:0] ERR_REJECTED = 2'd3;

  // CRC-16/XMODEM
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // silence timer
  localparam int          TIMER_W         = 20;
  localparam logic [19:0] TIMER_MAX       = 20'hFFFFF;
  localparam logic [19:0] DEFAULT_TIMEOUT = 20'd60000;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic       block_good;
    logic       block_bad;
    logic [7:0] block_number;
    logic       finished;
    logic [1:0] error_code;
  } result_t;

endpackage

// ----- src/xcr_if.sv -----
// ----------------------------------------------------------------------------
// xcr_item_if / xcr_result_if
// Valid/ready channels for received words and result words.
// ----------------------------------------------------------------------------
interface xcr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface xcr_result_if;
  logic       valid;
  logic       ready;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [6:0] data_index;
  logic       block_good;
  logic       block_bad;
  logic [7:0] block_number;
  logic       finished;
  logic [1:0] error_code;

  modport source (output valid, output reply_valid, output reply_byte,
                  output data_valid, output data_byte, output data_index,
                  output block_good, output block_bad, output block_number,
                  output finished, output error_code, input ready);
  modport sink   (input valid, input reply_valid, input reply_byte,
                  input data_valid, input data_byte, input data_index,
                  input block_good, input block_bad, input block_number,
                  input finished, input error_code, output ready);
endinterface

// ----- src/xmodem_crc_receiver.sv -----
// ----------------------------------------------------------------------------
// xmodem_crc_receiver
// Receive side of XMODEM-CRC: handshake replies, block checks, data stream.
// ----------------------------------------------------------------------------
// Every input word produces exactly one result word. The block takes one word
// per clock when the result side keeps up; an accepted word passes through the
// input register and then the result register. The one-cycle rate
// is set by the protocol state update, whose longest path is the byte-wide
// CRC-16 update feeding the running CRC register. A full result register does
// not stop intake until the input register is also occupied. No clearing pass
// is needed after reset. Configure timeout_limit (milliseconds, 0 = 60000)
// through cfg_we/cfg_data while the block is idle.
// ----------------------------------------------------------------------------
module xmodem_crc_receiver (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [19:0]  cfg_data,
  xcr_item_if.sink     item,
  xcr_result_if.source result
);
  import xcr_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  result_t res;

  assign in_item.action  = item.action;
  assign in_item.rx_byte = item.rx_byte;

  // input register
  xcr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  // protocol engine and result register
  xcr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res        (res)
  );

  // unpack the result word onto the channel
  assign result.reply_valid  = res.reply_valid;
  assign result.reply_byte   = res.reply_byte;
  assign result.data_valid   = res.data_valid;
  assign result.data_byte    = res.data_byte;
  assign result.data_index   = res.data_index;
  assign result.block_good   = res.block_good;
  assign result.block_bad    = res.block_bad;
  assign result.block_number = res.block_number;
  assign result.finished     = res.finished;
  assign result.error_code   = res.error_code;

endmodule

// ----- src/xcr_crc16.sv -----
// ----------------------------------------------------------------------------
// xcr_crc16
// One-byte CRC-16 update, polynomial 0x1021, MSB first.
// ----------------------------------------------------------------------------
module xcr_crc16 (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);
  import xcr_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_next = c;
  end

endmodule

// ----- src/xcr_in_stage.sv -----
// ----------------------------------------------------------------------------
// xcr_in_stage
// Input register: captures one word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module xcr_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  xcr_pkg::item_t in_item,
  output logic           held_valid,
  output xcr_pkg::item_t held_item,
  input  logic           take
);
  import xcr_pkg::*;

  // free when empty or when the held word leaves this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- src/xcr_core.sv -----
// ----------------------------------------------------------------------------
// xcr_core
// Protocol state, block checks, silence timer and the result register.
// ----------------------------------------------------------------------------
module xcr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [19:0]      cfg_data,
  input  logic             held_valid,
  input  xcr_pkg::item_t   held_item,
  output logic             take,
  output logic             res_valid,
  input  logic             res_ready,
  output xcr_pkg::result_t res
);
  import xcr_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_WAIT   = 4'd1;
  localparam logic [3:0] ST_NUM    = 4'd2;
  localparam logic [3:0] ST_CMP    = 4'd3;
  localparam logic [3:0] ST_DATA   = 4'd4;
  localparam logic [3:0] ST_CRCH   = 4'd5;
  localparam logic [3:0] ST_CRCL   = 4'd6;
  localparam logic [3:0] ST_DONE   = 4'd7;
  localparam logic [3:0] ST_FAILED = 4'd8;

  logic [TIMER_W-1:0] timeout_limit;
  logic [3:0]         phase, phase_next;
  logic [7:0]         expected_block, expected_block_next;
  logic [7:0]         header_number, header_number_next;
  logic [7:0]         header_complement, header_complement_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [15:0]        crc_running, crc_running_next;
  logic [7:0]         crc_high_received, crc_high_received_next;
  logic [TIMER_W-1:0] silence_timer, silence_timer_next;
  result_t            res_next;

  logic [15:0]        crc_step;
  logic [TIMER_W-1:0] limit;
  logic [TIMER_W-1:0] timer_inc;
  logic               running;
  logic               num_ok;

  xcr_crc16 u_crc (
    .crc      (crc_running),
    .data     (held_item.rx_byte),
    .crc_next (crc_step)
  );

  // word moves into the result register when that register is free
  assign take = held_valid && (!res_valid || res_ready);

  assign running   = (phase >= ST_WAIT) && (phase <= ST_CRCL);
  assign limit     = (timeout_limit == '0) ? DEFAULT_TIMEOUT : timeout_limit;
  assign timer_inc = (silence_timer < TIMER_MAX) ? silence_timer + 1'b1 : silence_timer;
  assign num_ok    = (header_number == expected_block) &&
                     (header_complement == ~expected_block);

  always_comb begin
    phase_next             = phase;
    expected_block_next    = expected_block;
    header_number_next     = header_number;
    header_complement_next = header_complement;
    byte_count_next        = byte_count;
    crc_running_next       = crc_running;
    crc_high_received_next = crc_high_received;
    silence_timer_next     = silence_timer;
    res_next               = '0;

    if (held_item.action == ACT_START) begin
      expected_block_next  = 8'd1;
      silence_timer_next   = '0;
      phase_next           = ST_WAIT;
      res_next.reply_valid = 1'b1;
      res_next.reply_byte  = B_REQ;
    end else if (!running) begin
      // idle, done or failed: nothing happens
    end else if (held_item.action == ACT_REJECT) begin
      phase_next           = ST_FAILED;
      res_next.reply_valid = 1'b1;
      res_next.reply_byte  = B_CAN;
      res_next.error_code  = ERR_REJECTED;
    end else if (held_item.action == ACT_TICK) begin
      silence_timer_next = timer_inc;
      if (timer_inc >= limit) begin
        phase_next          = ST_FAILED;
        res_next.error_code = ERR_TIMEOUT;
      end
    end else begin
      silence_timer_next = '0;
      unique case (phase)
        ST_WAIT: begin
          if (held_item.rx_byte == B_EOT) begin
            phase_next           = ST_DONE;
            res_next.reply_valid = 1'b1;
            res_next.reply_byte  = B_ACK;
            res_next.finished    = 1'b1;
          end else if (held_item.rx_byte == B_CAN) begin
            phase_next          = ST_FAILED;
            res_next.error_code = ERR_CANCEL;
          end else if (held_item.rx_byte == B_SOH) begin
            phase_next = ST_NUM;
          end
        end
        ST_NUM: begin
          header_number_next = held_item.rx_byte;
          phase_next         = ST_CMP;
        end
        ST_CMP: begin
          header_complement_next = held_item.rx_byte;
          byte_count_next        = '0;
          crc_running_next       = '0;
          phase_next             = ST_DATA;
        end
        ST_DATA: begin
          crc_running_next    = crc_step;
          res_next.data_valid = 1'b1;
          res_next.data_byte  = held_item.rx_byte;
          res_next.data_index = byte_count[6:0];
          if (byte_count == CNT_W'(BLOCK_BYTES - 1)) begin
            byte_count_next = '0;
            phase_next      = ST_CRCH;
          end else begin
            byte_count_next = byte_count + 1'b1;
          end
        end
        ST_CRCH: begin
          crc_high_received_next = held_item.rx_byte;
          phase_next             = ST_CRCL;
        end
        default: begin
          res_next.reply_valid = 1'b1;
          if (num_ok && ({crc_high_received, held_item.rx_byte} == crc_running)) begin
            res_next.reply_byte   = B_ACK;
            res_next.block_good   = 1'b1;
            res_next.block_number = header_number;
            expected_block_next   = expected_block + 8'd1;
          end else begin
            res_next.reply_byte = B_NAK;
            res_next.block_bad  = 1'b1;
          end
          phase_next = ST_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= '0;
    end else if (cfg_we) begin
      timeout_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= ST_IDLE;
      expected_block    <= 8'd1;
      header_number     <= '0;
      header_complement <= '0;
      byte_count        <= '0;
      crc_running       <= '0;
      crc_high_received <= '0;
      silence_timer     <= '0;
    end else if (take) begin
      phase             <= phase_next;
      expected_block    <= expected_block_next;
      header_number     <= header_number_next;
      header_complement <= header_complement_next;
      byte_count        <= byte_count_next;
      crc_running       <= crc_running_next;
      crc_high_received <= crc_high_received_next;
      silence_timer     <= silence_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

// ----- tb/xcr_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xcr_tb_pkg
// Transfer predictor and result scoreboard for the XMODEM-CRC receiver bench.
// ----------------------------------------------------------------------------
package xcr_tb_pkg;
  import xcr_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAIT, PH_NUM, PH_CMP, PH_DATA, PH_CRC_HI, PH_CRC_LO, PH_DONE, PH_FAILED
  } xfer_phase_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  class xmodem_rx_model;
    xfer_phase_t phase;
    logic [7:0]  expected_block;
    logic [7:0]  header_number;
    logic [7:0]  header_complement;
    logic [7:0]  crc_high;
    logic [15:0] crc_running;
    logic [19:0] silence_ms;
    logic [19:0] limit_setting;
    int          byte_count;
    result_t     pending_results[$];
    int          mismatches;
    int          words_checked;

    function void reset_state();
      phase             = PH_IDLE;
      expected_block    = 8'd1;
      header_number     = '0;
      header_complement = '0;
      crc_high          = '0;
      crc_running       = '0;
      silence_ms        = '0;
      limit_setting     = '0;
      byte_count        = 0;
      pending_results.delete();
      mismatches        = 0;
      words_checked     = 0;
    endfunction

    function void set_timeout(logic [19:0] ms);
      limit_setting = ms;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // accepted input word -> expected result word
    function void note_word(logic [1:0] act, logic [7:0] b);
      result_t     r;
      logic [19:0] lim;
      logic [15:0] rx_crc;
      bit          running;
      r = '0;
      running = phase inside {PH_WAIT, PH_NUM, PH_CMP, PH_DATA, PH_CRC_HI, PH_CRC_LO};
      if (act == ACT_START) begin
        expected_block = 8'd1;
        silence_ms     = '0;
        phase          = PH_WAIT;
        r.reply_valid  = 1'b1;
        r.reply_byte   = B_REQ;
      end else if (!running) begin
        // idle, done or failed: nothing happens
      end else if (act == ACT_REJECT) begin
        phase        = PH_FAILED;
        r.reply_valid = 1'b1;
        r.reply_byte  = B_CAN;
        r.error_code  = ERR_REJECTED;
      end else if (act == ACT_TICK) begin
        lim = (limit_setting == '0) ? DEFAULT_TIMEOUT : limit_setting;
        if (silence_ms != TIMER_MAX) silence_ms++;
        if (silence_ms >= lim) begin
          phase        = PH_FAILED;
          r.error_code = ERR_TIMEOUT;
        end
      end else begin
        silence_ms = '0;
        case (phase)
          PH_WAIT: begin
            if (b == B_EOT) begin
              phase         = PH_DONE;
              r.reply_valid = 1'b1;
              r.reply_byte  = B_ACK;
              r.finished    = 1'b1;
            end else if (b == B_CAN) begin
              phase        = PH_FAILED;
              r.error_code = ERR_CANCEL;
            end else if (b == B_SOH) begin
              phase = PH_NUM;
            end
          end
          PH_NUM: begin
            header_number = b;
            phase         = PH_CMP;
          end
          PH_CMP: begin
            header_complement = b;
            byte_count        = 0;
            crc_running       = '0;
            phase             = PH_DATA;
          end
          PH_DATA: begin
            crc_running  = crc16_step(crc_running, b);
            r.data_valid = 1'b1;
            r.data_byte  = b;
            r.data_index = 7'(byte_count);
            byte_count++;
            if (byte_count >= BLOCK_BYTES) begin
              byte_count = 0;
              phase      = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            crc_high = b;
            phase    = PH_CRC_LO;
          end
          default: begin
            rx_crc        = {crc_high, b};
            r.reply_valid = 1'b1;
            if (header_number == expected_block && header_complement == ~expected_block &&
                rx_crc == crc_running) begin
              r.reply_byte   = B_ACK;
              r.block_good   = 1'b1;
              r.block_number = header_number;
              expected_block = expected_block + 8'd1;
            end else begin
              r.reply_byte = B_NAK;
              r.block_bad  = 1'b1;
            end
            phase = PH_WAIT;
          end
        endcase
      end
      pending_results.push_back(r);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH word %0d: %s", words_checked, msg);
    endfunction

    function void compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result word with no input word outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare_field("reply_valid", 16'(got.reply_valid), 16'(want.reply_valid));
      compare_field("reply_byte", 16'(got.reply_byte), 16'(want.reply_byte));
      compare_field("data_valid", 16'(got.data_valid), 16'(want.data_valid));
      compare_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
      compare_field("data_index", 16'(got.data_index), 16'(want.data_index));
      compare_field("block_good", 16'(got.block_good), 16'(want.block_good));
      compare_field("block_bad", 16'(got.block_bad), 16'(want.block_bad));
      compare_field("block_number", 16'(got.block_number), 16'(want.block_number));
      compare_field("finished", 16'(got.finished), 16'(want.finished));
      compare_field("error_code", 16'(got.error_code), 16'(want.error_code));
      words_checked++;
    endfunction
  endclass

endpackage

// ----- tb/tb_xmodem_crc_receiver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xmodem_crc_receiver
// Self-checking bench: drives XMODEM-CRC transfers (good, damaged, repeated
// and cut-off blocks, cancels, rejects, timeouts) through the word channel and
// checks every result word against a cycle-free transfer predictor.
// ----------------------------------------------------------------------------
module tb_xmodem_crc_receiver;
  import xcr_pkg::*;
  import xcr_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 4;    // two-stage pipe plus margin
  localparam int PHASE_WORDS  = 80;

  // block damage kinds
  localparam int FLAW_NONE       = 0;
  localparam int FLAW_NUMBER     = 1;
  localparam int FLAW_COMPLEMENT = 2;
  localparam int FLAW_CRC_HI     = 3;
  localparam int FLAW_CRC_LO     = 4;

  // how a transfer ends
  localparam int END_EOT     = 0;
  localparam int END_CANCEL  = 1;
  localparam int END_REJECT  = 2;
  localparam int END_TIMEOUT = 3;
  localparam int END_OPEN    = 4;

  // result-side stall patterns
  localparam logic [1:0] RX_FREE     = 2'd0;
  localparam logic [1:0] RX_PERIODIC = 2'd1;
  localparam logic [1:0] RX_RANDOM   = 2'd2;
  localparam logic [1:0] RX_LONG     = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [19:0] cfg_data;

  xcr_item_if   item_ch();
  xcr_result_if res_ch();

  xmodem_crc_receiver uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (res_ch)
  );

  xmodem_rx_model model;

  int         burst_left;   // words left in the current sender burst
  bit         sender_calm;  // no sender gaps for this transfer
  int         stim_count;   // accepted input words
  int         quiet_ms;     // ticks since last byte or start, sender's own count
  int         limit_ms;     // effective timeout as currently programmed
  int         stall_cyc;
  logic [1:0] stall_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall pattern picked at random per window, including
  // windows with no stalls at all. The periodic and long patterns repeat regularly;
  // the random one can give longer stalls now and then.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_cyc = 0;
      stall_mode = RX_FREE;
    end else begin
      stall_cyc++;
      if (stall_cyc % 300 == 0) stall_mode = 2'($urandom_range(0, 3));
      case (stall_mode)
        RX_FREE:     res_ch.ready <= 1'b1;
        RX_PERIODIC: res_ch.ready <= (stall_cyc % 7) != 2 && (stall_cyc % 7) != 3;
        RX_RANDOM:   res_ch.ready <= $urandom_range(0, 2) != 0;
        default:     res_ch.ready <= (stall_cyc % 12) < 4;
      endcase
    end
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      model.check_result('{reply_valid:  res_ch.reply_valid,
                           reply_byte:   res_ch.reply_byte,
                           data_valid:   res_ch.data_valid,
                           data_byte:    res_ch.data_byte,
                           data_index:   res_ch.data_index,
                           block_good:   res_ch.block_good,
                           block_bad:    res_ch.block_bad,
                           block_number: res_ch.block_number,
                           finished:     res_ch.finished,
                           error_code:   res_ch.error_code});
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // One input word. Bursts of 1..10 words back to back, random gaps between
  // bursts unless the transfer runs calm. Inputs change on the falling edge.
  task automatic push_word(input logic [1:0] act, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = (sender_calm || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_ch.valid   <= 1'b1;
    item_ch.action  <= act;
    item_ch.rx_byte <= b;
    do @(posedge clk); while (!item_ch.ready);
    model.note_word(act, b);
    stim_count++;
    if (act == ACT_TICK) quiet_ms++;
    else if (act == ACT_START || act == ACT_BYTE) quiet_ms = 0;
  endtask

  // Sender holds off until every outstanding result word has come back.
  task automatic drain_results();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (model.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only written with the pipe empty.
  task automatic write_timeout(input logic [19:0] ms);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= ms;
    @(negedge clk);
    cfg_we   <= 1'b0;
    model.set_timeout(ms);
    limit_ms = (ms == '0) ? int'(DEFAULT_TIMEOUT) : int'(ms);
  endtask

  // A few ticks that stay short of the timeout.
  task automatic tick_burst();
    int room;
    room = limit_ms - 1 - quiet_ms;
    if (room > 0) repeat ($urandom_range(1, room < 4 ? room : 4)) push_word(ACT_TICK, 8'($urandom));
  endtask

  // Full block: header, 128 data bytes, CRC. One flaw at most, as a single
  // flipped bit in the number, complement or one CRC byte.
  task automatic send_block(input logic [7:0] blk, input int flaw);
    logic [15:0] crc;
    logic [7:0]  num, cmp, b;
    int          fill;
    num  = blk;
    cmp  = ~blk;
    fill = $urandom_range(0, 9);
    if (flaw == FLAW_NUMBER) num ^= 8'(1 << $urandom_range(0, 7));
    if (flaw == FLAW_COMPLEMENT) cmp ^= 8'(1 << $urandom_range(0, 7));
    push_word(ACT_BYTE, B_SOH);
    push_word(ACT_BYTE, num);
    push_word(ACT_BYTE, cmp);
    crc = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      crc = crc16_step(crc, b);
      push_word(ACT_BYTE, b);
      if ($urandom_range(0, 40) == 0) tick_burst();
    end
    if (flaw == FLAW_CRC_HI) crc ^= 16'(1 << $urandom_range(8, 15));
    if (flaw == FLAW_CRC_LO) crc ^= 16'(1 << $urandom_range(0, 7));
    push_word(ACT_BYTE, crc[15:8]);
    push_word(ACT_BYTE, crc[7:0]);
  endtask

  // One transfer: mostly well-formed blocks, plus damaged and repeated
  // blocks, line noise, ticks, and a block cut off part way.
  task automatic run_transfer(input int stop_at);
    logic [7:0] next_blk;
    logic [7:0] b;
    int         pick;
    int         flaw;
    int         ending;
    bit         mid_block;
    sender_calm = ($urandom_range(0, 3) == 0);
    next_blk    = 8'd1;
    mid_block   = 1'b0;
    push_word(ACT_START, 8'($urandom));
    while (stim_count < stop_at && !mid_block) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(FLAW_NUMBER, FLAW_CRC_LO) : FLAW_NONE;
        send_block(next_blk, flaw);
        if (flaw == FLAW_NONE) next_blk++;
      end else if (pick < 55) begin
        // sender repeats the last block: still a number mismatch, NAKed
        send_block(next_blk - 8'd1, FLAW_NONE);
      end else if (pick < 70) begin
        b = 8'($urandom);
        if (b == B_SOH || b == B_EOT || b == B_CAN) b ^= 8'h80;
        push_word(ACT_BYTE, b);
      end else if (pick < 85) begin
        tick_burst();
      end else begin
        push_word(ACT_BYTE, B_SOH);
        push_word(ACT_BYTE, next_blk);
        push_word(ACT_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : ~next_blk);
        repeat ($urandom_range(0, 12)) push_word(ACT_BYTE, 8'($urandom));
        mid_block = 1'b1;
      end
    end

    pick = $urandom_range(0, 9);
    if (mid_block) ending = (pick < 4) ? END_REJECT : (pick < 7) ? END_TIMEOUT : END_OPEN;
    else ending = (pick < 4) ? END_EOT : (pick < 5) ? END_CANCEL :
                  (pick < 7) ? END_REJECT : (pick < 9) ? END_TIMEOUT : END_OPEN;
    if (ending == END_TIMEOUT && limit_ms > 64) ending = END_REJECT;
    case (ending)
      END_EOT:     push_word(ACT_BYTE, B_EOT);
      END_CANCEL:  push_word(ACT_BYTE, B_CAN);
      END_REJECT:  push_word(ACT_REJECT, 8'($urandom));
      END_TIMEOUT: while (quiet_ms < limit_ms) push_word(ACT_TICK, 8'($urandom));
      default:     ; // left running; the next start restarts it
    endcase
    // stray words after the end, ignored unless the transfer was left open
    repeat ($urandom_range(0, 2)) push_word(2'($urandom_range(1, 3)), 8'($urandom));
  endtask

  task automatic run_phase(input int words);
    int stop_at;
    stop_at = stim_count + words;
    while (stim_count < stop_at) run_transfer(stop_at);
  endtask

  initial begin
    model = new();
    model.reset_state();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    item_ch.action  = ACT_START;
    item_ch.rx_byte = '0;
    burst_left      = 0;
    sender_calm     = 1'b0;
    stim_count      = 0;
    quiet_ms        = 0;
    limit_ms        = int'(DEFAULT_TIMEOUT);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed: short timeout so the silence rules show up quickly ----
    write_timeout(20'd3);
    // before any start everything is ignored
    push_word(ACT_BYTE, B_SOH);
    push_word(ACT_TICK, 8'hFF);
    push_word(ACT_REJECT, 8'h00);
    push_word(ACT_START, 8'hFF);
    // noise in the wait state, byte extremes
    push_word(ACT_BYTE, 8'h00);
    push_word(ACT_BYTE, 8'hFF);
    // a byte clears the silence timer; third tick after it times out
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_BYTE, 8'h7E);
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_TICK, 8'h00);
    // failed transfer ignores everything
    push_word(ACT_TICK, 8'h00);
    push_word(ACT_BYTE, B_EOT);
    // EOT completes; done state ignores words
    push_word(ACT_START, 8'h00);
    push_word(ACT_BYTE, B_EOT);
    push_word(ACT_BYTE, B_SOH);
    push_word(ACT_REJECT, 8'hFF);
    // sender cancel, then sink reject
    push_word(ACT_START, 8'h00);
    push_word(ACT_BYTE, B_CAN);
    push_word(ACT_START, 8'h00);
    push_word(ACT_REJECT, 8'h00);
    // start while running, and again in the middle of a block
    push_word(ACT_START, 8'h00);
    push_word(ACT_START, 8'h00);
    push_word(ACT_BYTE, B_SOH);
    push_word(ACT_BYTE, 8'h01);
    push_word(ACT_BYTE, 8'hFE);
    push_word(ACT_BYTE, 8'h00);
    push_word(ACT_BYTE, 8'hFF);
    push_word(ACT_START, 8'h00);
    push_word(ACT_REJECT, 8'h00);

    // ---- zero selects the 60000 ms default: a run of ticks stays below it ----
    write_timeout(20'd0);
    push_word(ACT_START, 8'h00);
    repeat (20) push_word(ACT_TICK, 8'($urandom));
    push_word(ACT_REJECT, 8'h00);

    // ---- random transfers under several timeout settings ----
    write_timeout(20'd1_000_000);
    run_phase(PHASE_WORDS);
    write_timeout(20'($urandom_range(2, 24)));
    run_phase(PHASE_WORDS);
    write_timeout(20'd1);
    run_phase(PHASE_WORDS);

    drain_results();
    if (model.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
